// ===== hdl/fss_pkg.sv =====
// fss_pkg: shared types for the fuzzy subsequence scorer
// holds the configuration bundle, the match class codes and the result bundle
// no dependencies
`timescale 1ns / 1ps

package fss_pkg;

    typedef enum logic [1:0] {
        CLASS_NONE   = 2'd0,
        CLASS_EXACT  = 2'd1,
        CLASS_PREFIX = 2'd2,
        CLASS_SUBSEQ = 2'd3
    } class_t;

    typedef struct packed {
        logic        [7:0]  weight_char;
        logic        [7:0]  weight_consec;
        logic        [7:0]  weight_start;
        logic        [7:0]  weight_boundary;
        logic        [7:0]  weight_gap;
        logic signed [15:0] miss_score;
        logic signed [15:0] exact_score;
        logic signed [15:0] prefix_score;
    } fss_cfg_t;

    typedef struct packed {
        logic signed [31:0] score;
        class_t             match_class;
    } fss_result_t;

endpackage

// ===== hdl/fuzzy_subsequence_scorer_top.sv =====
// Fuzzy subsequence scorer. Items are taken at one per cycle while not stalled, whatever their kind:
// kind 0 appends a pattern byte, 1 streams a text byte, 2 ends the text and
// produces one result, 3 clears the pattern; appends and clears also restart the
// text scan. The pattern sits in a dual-read memory whose registered read data
// always holds the bytes at the current text position and match position, so a
// text byte is scored in the cycle it is accepted. A result appears in the
// output register on the cycle after its end of text item and the input is
// stalled only while that register is full and stalled itself. Configuration
// registers are always ready and may be written only while no item is in flight.
// depends on fss_pkg, fss_pattern_mem, fss_scan
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_top
    import fss_pkg::*;
#(
    parameter int PATTERN_DEPTH   = 256,
    parameter int TEXT_COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         text_byte,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] score,
    output logic [1:0]         match_class,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = $clog2(PATTERN_DEPTH);

    typedef enum logic [2:0] {
        REG_WEIGHT_CHAR     = 3'd0,
        REG_WEIGHT_CONSEC   = 3'd1,
        REG_WEIGHT_START    = 3'd2,
        REG_WEIGHT_BOUNDARY = 3'd3,
        REG_WEIGHT_GAP      = 3'd4,
        REG_MISS_SCORE      = 3'd5,
        REG_EXACT_SCORE     = 3'd6,
        REG_PREFIX_SCORE    = 3'd7
    } cfg_reg_t;

    fss_cfg_t    cfg_reg;
    fss_result_t result_reg;
    logic        result_valid_reg;

    logic          item_fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [7:0]    rd_data_a;
    logic [7:0]    rd_data_b;
    logic          scan_result_fire;
    fss_result_t   scan_result;

    assign cfg_ready  = 1'b1;
    assign text_stall = result_valid_reg && result_stall;
    assign item_fire  = text_valid && !text_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_char     <= 8'd16;
            cfg_reg.weight_consec   <= 8'd8;
            cfg_reg.weight_start    <= 8'd32;
            cfg_reg.weight_boundary <= 8'd24;
            cfg_reg.weight_gap      <= 8'd1;
            cfg_reg.miss_score      <= 16'sd0;
            cfg_reg.exact_score     <= 16'sd10000;
            cfg_reg.prefix_score    <= 16'sd5000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WEIGHT_CHAR:     cfg_reg.weight_char     <= cfg_data[7:0];
                REG_WEIGHT_CONSEC:   cfg_reg.weight_consec   <= cfg_data[7:0];
                REG_WEIGHT_START:    cfg_reg.weight_start    <= cfg_data[7:0];
                REG_WEIGHT_BOUNDARY: cfg_reg.weight_boundary <= cfg_data[7:0];
                REG_WEIGHT_GAP:      cfg_reg.weight_gap      <= cfg_data[7:0];
                REG_MISS_SCORE:      cfg_reg.miss_score      <= cfg_data;
                REG_EXACT_SCORE:     cfg_reg.exact_score     <= cfg_data;
                REG_PREFIX_SCORE:    cfg_reg.prefix_score    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fss_pattern_mem #(
        .DEPTH (PATTERN_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    fss_scan #(
        .PATTERN_DEPTH   (PATTERN_DEPTH),
        .TEXT_COUNT_BITS (TEXT_COUNT_BITS),
        .AW              (AW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_fire   (item_fire),
        .kind        (kind),
        .text_byte   (text_byte),
        .cfg         (cfg_reg),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .result_fire (scan_result_fire),
        .result      (scan_result)
    );

    // output register, refilled in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (scan_result_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_result_fire)
        begin
            result_reg <= scan_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign score        = result_reg.score;
    assign match_class  = result_reg.match_class;

endmodule

// ===== hdl/fss_pattern_mem.sv =====
// fss_pattern_mem: pattern byte store, one write port and two read ports
// read data is registered; a write to the address being read is forwarded
// no dependencies
`timescale 1ns / 1ps

module fss_pattern_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [7:0]    rd_data_a,
    output logic [7:0]    rd_data_b
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first behavior so a freshly appended byte is seen at once
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr_a))
        begin
            rd_data_a_reg <= wr_data;
        end
        else
        begin
            rd_data_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b))
        begin
            rd_data_b_reg <= wr_data;
        end
        else
        begin
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== hdl/fss_scan.sv =====
// fss_scan: text scan state, score update and end of text decision
// drives the pattern store addresses from next state so read data is ready
// depends on fss_pkg
`timescale 1ns / 1ps

module fss_scan
    import fss_pkg::*;
#(
    parameter int PATTERN_DEPTH   = 256,
    parameter int TEXT_COUNT_BITS = 16,
    parameter int AW              = $clog2(PATTERN_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_fire,
    input  logic [1:0]    kind,
    input  logic [7:0]    text_byte,
    input  fss_cfg_t      cfg,
    input  logic [7:0]    rd_data_a,
    input  logic [7:0]    rd_data_b,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic [AW-1:0] rd_addr_a,
    output logic [AW-1:0] rd_addr_b,
    output logic          result_fire,
    output fss_result_t   result
);

    localparam int LW   = $clog2(PATTERN_DEPTH + 1);
    localparam int CW   = (TEXT_COUNT_BITS > LW) ? TEXT_COUNT_BITS : LW;
    localparam int IW   = LW + 11;
    localparam int SW   = 34;
    localparam int DW   = ((TEXT_COUNT_BITS > 32) ? TEXT_COUNT_BITS : 32) + 2;
    localparam logic signed [SW-1:0] S32_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S32_MIN = -SW'(64'sd2147483648);
    localparam logic [TEXT_COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_END    = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;

    kind_t kind_code;

    logic [LW-1:0]              pattern_len_reg, pattern_len_next;
    logic [LW-1:0]              match_idx_reg, match_idx_next;
    logic [LW-1:0]              run_len_reg, run_len_next;
    logic                       in_run_reg, in_run_next;
    logic                       started_reg, started_next;
    logic [7:0]                 prev_byte_reg, prev_byte_next;
    logic [TEXT_COUNT_BITS-1:0] text_cnt_reg, text_cnt_next;
    logic                       equal_reg, equal_next;
    logic signed [31:0]         run_score_reg, run_score_next;

    logic [CW-1:0]       tc_ext;
    logic [CW-1:0]       len_ext;
    logic [CW-1:0]       tc_next_ext;
    logic [LW:0]         run_plus;
    logic [LW+8:0]       consec_prod;
    logic [7:0]          pos_bonus;
    logic [IW-1:0]       score_inc;
    logic signed [SW-1:0] run_ext;
    logic signed [SW-1:0] sum_hit;
    logic signed [SW-1:0] sum_gap;
    logic signed [DW-1:0] final_diff;
    logic                 boundary_prev;

    assign kind_code = kind_t'(kind);
    assign tc_ext    = CW'(text_cnt_reg);
    assign len_ext   = CW'(pattern_len_reg);

    assign boundary_prev = (prev_byte_reg == CH_SLASH) || (prev_byte_reg == CH_UNDERSCORE)
                        || (prev_byte_reg == CH_HYPHEN) || (prev_byte_reg == CH_DOT);

    // increment for a hit depends on registers only, not on the compare
    assign run_plus    = {1'b0, run_len_reg} + 1'b1;
    assign consec_prod = (LW + 9)'(run_plus) * (LW + 9)'(cfg.weight_consec);
    assign pos_bonus   = (text_cnt_reg == '0) ? cfg.weight_start
                       : (boundary_prev ? cfg.weight_boundary : 8'd0);
    assign score_inc   = IW'(cfg.weight_char) + (in_run_reg ? IW'(consec_prod) : IW'(0))
                       + IW'(pos_bonus);

    assign run_ext = {{(SW - 32){run_score_reg[31]}}, run_score_reg};
    assign sum_hit = run_ext + $signed(SW'(score_inc));
    assign sum_gap = run_ext - $signed(SW'(cfg.weight_gap));
    assign final_diff = $signed({{(DW - 32){run_score_reg[31]}}, run_score_reg})
                      - $signed(DW'(text_cnt_reg));

    always_comb
    begin
        pattern_len_next = pattern_len_reg;
        match_idx_next   = match_idx_reg;
        run_len_next     = run_len_reg;
        in_run_next      = in_run_reg;
        started_next     = started_reg;
        prev_byte_next   = prev_byte_reg;
        text_cnt_next    = text_cnt_reg;
        equal_next       = equal_reg;
        run_score_next   = run_score_reg;
        wr_en            = 1'b0;
        result_fire      = 1'b0;
        if (item_fire)
        begin
            if (kind_code == KIND_TEXT)
            begin
                if (equal_reg && (tc_ext < len_ext) && (rd_data_a != text_byte))
                begin
                    equal_next = 1'b0;
                end
                if (match_idx_reg < pattern_len_reg)
                begin
                    if (rd_data_b == text_byte)
                    begin
                        started_next   = 1'b1;
                        match_idx_next = match_idx_reg + 1'b1;
                        in_run_next    = 1'b1;
                        run_len_next   = in_run_reg ? LW'(run_plus) : LW'(1);
                        run_score_next = (sum_hit > S32_MAX) ? 32'sh7FFF_FFFF : sum_hit[31:0];
                    end
                    else
                    begin
                        in_run_next  = 1'b0;
                        run_len_next = '0;
                        if (started_reg)
                        begin
                            run_score_next = (sum_gap < S32_MIN) ? 32'sh8000_0000
                                                                 : sum_gap[31:0];
                        end
                    end
                end
                prev_byte_next = text_byte;
                if (text_cnt_reg != COUNT_MAX)
                begin
                    text_cnt_next = text_cnt_reg + 1'b1;
                end
            end
            else
            begin
                // append, clear and end of text all restart the scan
                match_idx_next = '0;
                run_len_next   = '0;
                in_run_next    = 1'b0;
                started_next   = 1'b0;
                prev_byte_next = '0;
                text_cnt_next  = '0;
                equal_next     = 1'b1;
                run_score_next = '0;
                case (kind_code)
                    KIND_APPEND:
                    begin
                        if (pattern_len_reg < LW'(PATTERN_DEPTH))
                        begin
                            wr_en            = 1'b1;
                            pattern_len_next = pattern_len_reg + 1'b1;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        pattern_len_next = '0;
                    end
                    KIND_END:
                    begin
                        result_fire = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (pattern_len_reg == '0)
        begin
            result.score       = {{16{cfg.miss_score[15]}}, cfg.miss_score};
            result.match_class = CLASS_NONE;
        end
        else if (equal_reg && (tc_ext == len_ext))
        begin
            result.score       = {{16{cfg.exact_score[15]}}, cfg.exact_score};
            result.match_class = CLASS_EXACT;
        end
        else if (equal_reg && (tc_ext > len_ext))
        begin
            result.score       = {{16{cfg.prefix_score[15]}}, cfg.prefix_score};
            result.match_class = CLASS_PREFIX;
        end
        else if (match_idx_reg < pattern_len_reg)
        begin
            result.score       = {{16{cfg.miss_score[15]}}, cfg.miss_score};
            result.match_class = CLASS_NONE;
        end
        else
        begin
            result.score       = (final_diff < DW'(1)) ? 32'sd1 : final_diff[31:0];
            result.match_class = CLASS_SUBSEQ;
        end
    end

    // read addresses follow next state so the bytes under both indexes are ready
    assign tc_next_ext = CW'(text_cnt_next);
    assign rd_addr_a   = tc_next_ext[AW-1:0];
    assign rd_addr_b   = match_idx_next[AW-1:0];
    assign wr_addr     = pattern_len_reg[AW-1:0];
    assign wr_data     = text_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
            match_idx_reg   <= '0;
            run_len_reg     <= '0;
            in_run_reg      <= 1'b0;
            started_reg     <= 1'b0;
            prev_byte_reg   <= '0;
            text_cnt_reg    <= '0;
            equal_reg       <= 1'b1;
            run_score_reg   <= '0;
        end
        else
        begin
            pattern_len_reg <= pattern_len_next;
            match_idx_reg   <= match_idx_next;
            run_len_reg     <= run_len_next;
            in_run_reg      <= in_run_next;
            started_reg     <= started_next;
            prev_byte_reg   <= prev_byte_next;
            text_cnt_reg    <= text_cnt_next;
            equal_reg       <= equal_next;
            run_score_reg   <= run_score_next;
        end
    end

endmodule

// ===== bench/fuzzy_subsequence_scorer_top_tb.sv =====
// fuzzy_subsequence_scorer_top_tb: self-checking bench for the fuzzy subsequence scorer
// a stimulus table, a full pattern with an over-long text, then random sequences under
// all-zero and then random weights and idle patterns; depends on fss_pkg and fuzzy_subsequence_scorer_top
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_top_tb;
    import fss_pkg::*;

    localparam int PAT_DEPTH    = 256;
    localparam int CNT_BITS     = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 130;
    localparam int MAX_REPORTS  = 200;
    localparam int DIR_ROWS     = 30;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_END    = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_WEIGHT_CHAR     = 3'd0,
        REG_WEIGHT_CONSEC   = 3'd1,
        REG_WEIGHT_START    = 3'd2,
        REG_WEIGHT_BOUNDARY = 3'd3,
        REG_WEIGHT_GAP      = 3'd4,
        REG_MISS_SCORE      = 3'd5,
        REG_EXACT_SCORE     = 3'd6,
        REG_PREFIX_SCORE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        kind_t              k;
        logic [7:0]         b;
        logic               pinned;
        logic signed [31:0] s;
        class_t             c;
    } stim_row_t;

    // pinned rows carry a result read straight off the reset weights
    stim_row_t dir_table [DIR_ROWS] = '{
        '{KIND_END,    8'h00, 1'b1, 32'sd0,     CLASS_NONE},   // empty pattern
        '{KIND_APPEND, 8'h61, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_APPEND, 8'h00, 1'b0, 32'sd0,     CLASS_NONE},   // zero byte in pattern
        '{KIND_TEXT,   8'h61, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h00, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_END,    8'h00, 1'b1, 32'sd10000, CLASS_EXACT},
        '{KIND_TEXT,   8'h61, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h00, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h2D, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_END,    8'hFF, 1'b1, 32'sd5000,  CLASS_PREFIX},
        '{KIND_TEXT,   8'h2F, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h61, 1'b0, 32'sd0,     CLASS_NONE},   // match after slash
        '{KIND_TEXT,   8'h5F, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h00, 1'b0, 32'sd0,     CLASS_NONE},   // match after underscore
        '{KIND_END,    8'h00, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'hFF, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_END,    8'h00, 1'b1, 32'sd0,     CLASS_NONE},   // pattern not matched
        '{KIND_CLEAR,  8'hFF, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h61, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_END,    8'h00, 1'b1, 32'sd0,     CLASS_NONE},   // cleared pattern
        '{KIND_APPEND, 8'hFF, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h01, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_APPEND, 8'h2E, 1'b0, 32'sd0,     CLASS_NONE},   // append mid-text restarts
        '{KIND_TEXT,   8'hFF, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h2E, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_END,    8'h00, 1'b1, 32'sd10000, CLASS_EXACT},
        '{KIND_TEXT,   8'hFF, 1'b0, 32'sd0,     CLASS_NONE},   // match on first byte
        '{KIND_TEXT,   8'h2D, 1'b0, 32'sd0,     CLASS_NONE},
        '{KIND_TEXT,   8'h2E, 1'b0, 32'sd0,     CLASS_NONE},   // match after hyphen
        '{KIND_END,    8'h00, 1'b0, 32'sd0,     CLASS_NONE}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               text_valid = 1'b0;
    logic               text_stall;
    logic [1:0]         kind = 2'd0;
    logic [7:0]         text_byte = 8'd0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] score;
    logic [1:0]         match_class;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = 3'd0;
    logic [15:0]        cfg_data = 16'd0;

    // expected result riding along with the item, for pinned table rows
    logic               pin_on = 1'b0;
    logic signed [31:0] pin_score = 32'sd0;
    class_t             pin_class = CLASS_NONE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_items = 0;
    int errors = 0;
    int cycles = 0;

    logic [7:0]  gen_pat [$];
    logic [7:0]  boundary_chars [4] = '{CH_SLASH, CH_UNDER, CH_DASH, CH_DOT};
    fss_result_t expected_results [$];

    // scorer state mirrored on the bench side
    fss_cfg_t           model_cfg;
    logic [7:0]         pat_mem [PAT_DEPTH];
    logic [8:0]         pat_len;
    logic [8:0]         match_pos;
    logic [8:0]         run_len;
    logic               in_run;
    logic               started;
    logic [7:0]         prev_ch;
    logic [CNT_BITS-1:0] txt_cnt;
    logic               eq_so_far;
    logic signed [31:0] run_score;

    fuzzy_subsequence_scorer_top #(
        .PATTERN_DEPTH   (PAT_DEPTH),
        .TEXT_COUNT_BITS (CNT_BITS)
    ) u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > S32_MAX)
            return S32_MAX[31:0];
        if (v < S32_MIN)
            return S32_MIN[31:0];
        return v[31:0];
    endfunction

    function automatic void restart_scan();
        match_pos = '0;
        run_len   = '0;
        in_run    = 1'b0;
        started   = 1'b0;
        prev_ch   = '0;
        txt_cnt   = '0;
        eq_so_far = 1'b1;
        run_score = '0;
    endfunction

    // advances the mirrored state by one item; returns 1 when the item ends a text
    function automatic bit score_item(input kind_t k, input logic [7:0] b,
                                      output fss_result_t r);
        longint acc;
        r = '0;
        case (k)
            KIND_APPEND:
            begin
                if (pat_len < PAT_DEPTH)
                begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end
                restart_scan();
                return 1'b0;
            end
            KIND_CLEAR:
            begin
                pat_len = '0;
                restart_scan();
                return 1'b0;
            end
            KIND_TEXT:
            begin
                if (eq_so_far && txt_cnt < pat_len && pat_mem[txt_cnt] != b)
                    eq_so_far = 1'b0;
                if (match_pos < pat_len)
                begin
                    if (b == pat_mem[match_pos])
                    begin
                        acc = longint'(run_score) + longint'(model_cfg.weight_char);
                        started = 1'b1;
                        if (in_run)
                        begin
                            run_len++;
                            acc += longint'(run_len) * longint'(model_cfg.weight_consec);
                        end
                        else
                        begin
                            run_len = 9'd1;
                            in_run  = 1'b1;
                        end
                        if (txt_cnt == 0)
                            acc += longint'(model_cfg.weight_start);
                        else if (prev_ch inside {CH_SLASH, CH_UNDER, CH_DASH, CH_DOT})
                            acc += longint'(model_cfg.weight_boundary);
                        run_score = sat32(acc);
                        match_pos++;
                    end
                    else
                    begin
                        in_run  = 1'b0;
                        run_len = '0;
                        if (started)
                            run_score = sat32(longint'(run_score)
                                              - longint'(model_cfg.weight_gap));
                    end
                end
                prev_ch = b;
                if (txt_cnt != '1)
                    txt_cnt++;
                return 1'b0;
            end
            default:
            begin
                if (pat_len == 0)
                begin
                    r.score       = model_cfg.miss_score;
                    r.match_class = CLASS_NONE;
                end
                else if (eq_so_far && txt_cnt == pat_len)
                begin
                    r.score       = model_cfg.exact_score;
                    r.match_class = CLASS_EXACT;
                end
                else if (eq_so_far && txt_cnt > pat_len)
                begin
                    r.score       = model_cfg.prefix_score;
                    r.match_class = CLASS_PREFIX;
                end
                else if (match_pos < pat_len)
                begin
                    r.score       = model_cfg.miss_score;
                    r.match_class = CLASS_NONE;
                end
                else
                begin
                    acc = longint'(run_score) - longint'(txt_cnt);
                    if (acc < 1)
                        acc = 1;
                    r.score       = acc[31:0];
                    r.match_class = CLASS_SUBSEQ;
                end
                restart_scan();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return boundary_chars[$urandom_range(3)];
            1: return 8'h00;
            2: return 8'hFF;
            3, 4:
            begin
                if (gen_pat.size() != 0)
                    return gen_pat[$urandom_range(gen_pat.size() - 1)];
                return 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_weight();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_fixed();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input kind_t k, input logic [7:0] b, input logic pin = 1'b0,
                             input logic signed [31:0] pin_s = 32'sd0,
                             input class_t pin_c = CLASS_NONE);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        kind       <= k;
        text_byte  <= b;
        pin_on     <= pin;
        pin_score  <= pin_s;
        pin_class  <= pin_c;
        if (k == KIND_APPEND && gen_pat.size() < PAT_DEPTH)
            gen_pat.push_back(b);
        if (k == KIND_CLEAR)
            gen_pat.delete();
        sent_items++;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
    endtask

    // lets every outstanding result come back, then idles with no item offered
    task automatic drain();
        text_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input fss_cfg_t c);
        reg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = reg_idx_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            // upper bits of the weight writes are junk and must be dropped
            case (idx)
                REG_WEIGHT_CHAR:     cfg_data <= {8'($urandom), c.weight_char};
                REG_WEIGHT_CONSEC:   cfg_data <= {8'($urandom), c.weight_consec};
                REG_WEIGHT_START:    cfg_data <= {8'($urandom), c.weight_start};
                REG_WEIGHT_BOUNDARY: cfg_data <= {8'($urandom), c.weight_boundary};
                REG_WEIGHT_GAP:      cfg_data <= {8'($urandom), c.weight_gap};
                REG_MISS_SCORE:      cfg_data <= c.miss_score;
                REG_EXACT_SCORE:     cfg_data <= c.exact_score;
                default:             cfg_data <= c.prefix_score;
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        model_cfg = c;
    endtask

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : accept_side
        fss_result_t want;
        if (rst_n && text_valid && !text_stall)
        begin
            if (score_item(kind_t'(kind), text_byte, want))
            begin
                if (pin_on)
                begin
                    want.score       = pin_score;
                    want.match_class = pin_class;
                end
                expected_results.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin : result_side
        fss_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result with none pending, score %0d class %0d",
                             $time, score, match_class);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (score !== want.score)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: score expected %0d, got %0d",
                                 $time, want.score, score);
                    errors++;
                end
                if (match_class !== want.match_class)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: match_class expected %0d, got %0d",
                                 $time, want.match_class, match_class);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        fss_cfg_t c;
        int mode;
        int phase_start;
        int n;
        int style;
        int cut;
        int flip;

        model_cfg = '{weight_char: 8'd16, weight_consec: 8'd8, weight_start: 8'd32,
                      weight_boundary: 8'd24, weight_gap: 8'd1, miss_score: 16'sd0,
                      exact_score: 16'sd10000, prefix_score: 16'sd5000};
        pat_len = '0;
        restart_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_item(dir_table[i].k, dir_table[i].b, dir_table[i].pinned,
                      dir_table[i].s, dir_table[i].c);
        drain();

        // top weights, full store, texts running past the pattern length
        c = '{weight_char: 8'hFF, weight_consec: 8'hFF, weight_start: 8'hFF,
              weight_boundary: 8'hFF, weight_gap: 8'hFF, miss_score: 16'sh7FFF,
              exact_score: 16'sh8000, prefix_score: 16'sh7FFF};
        load_config(c);
        send_item(KIND_CLEAR, 8'h00);
        repeat (PAT_DEPTH) send_item(KIND_APPEND, 8'h41);
        repeat (4) send_item(KIND_APPEND, 8'h42);   // store full, dropped
        repeat (PAT_DEPTH) send_item(KIND_TEXT, 8'h41);
        send_item(KIND_END, 8'h00);
        repeat (PAT_DEPTH) send_item(KIND_TEXT, 8'h41);
        send_item(KIND_TEXT, 8'h42);
        send_item(KIND_END, 8'h00);
        send_item(KIND_TEXT, 8'h00);
        repeat (PAT_DEPTH) send_item(KIND_TEXT, 8'h41);
        send_item(KIND_END, 8'h00);
        send_item(KIND_CLEAR, 8'h00);
        drain();

        c = '{weight_char: 8'h00, weight_consec: 8'h00, weight_start: 8'h00,
              weight_boundary: 8'h00, weight_gap: 8'h00, miss_score: 16'sh8000,
              exact_score: 16'sh7FFF, prefix_score: 16'sh8000};
        load_config(c);

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 2)
                begin
                    // stray item of any kind, pattern edits mid-text included
                    send_item(kind_t'($urandom_range(3)), pick_byte());
                end
                else
                begin
                    if (gen_pat.size() == 0 || gen_pat.size() > 40 || $urandom_range(3) != 0)
                    begin
                        if ($urandom_range(3) != 0)
                            send_item(KIND_CLEAR, 8'($urandom));
                        case ($urandom_range(19))
                            0: n = 0;
                            1: n = $urandom_range(40, 20);
                            default: n = $urandom_range(8, 1);
                        endcase
                        repeat (n) send_item(KIND_APPEND, pick_byte());
                    end
                    repeat ($urandom_range(4, 1))
                    begin
                        style = $urandom_range(9);
                        case (style)
                            0, 1, 2:
                            begin
                                foreach (gen_pat[i])
                                    send_item(KIND_TEXT, gen_pat[i]);
                                if (style == 2)
                                    repeat ($urandom_range(4, 1))
                                        send_item(KIND_TEXT, pick_byte());
                            end
                            3:
                            begin
                                flip = $urandom_range(gen_pat.size());
                                foreach (gen_pat[i])
                                    send_item(KIND_TEXT, (i == flip)
                                              ? gen_pat[i] ^ 8'($urandom_range(255, 1))
                                              : gen_pat[i]);
                            end
                            4:
                            begin
                                repeat ($urandom_range(10))
                                    send_item(KIND_TEXT, pick_byte());
                            end
                            default:
                            begin
                                // pattern spread out with filler, sometimes cut short
                                cut = gen_pat.size();
                                if (style == 9 && cut > 0)
                                    cut = $urandom_range(cut - 1);
                                for (int i = 0; i < cut; i++)
                                begin
                                    repeat ($urandom_range(3))
                                        send_item(KIND_TEXT, pick_byte());
                                    send_item(KIND_TEXT, gen_pat[i]);
                                end
                                repeat ($urandom_range(3))
                                    send_item(KIND_TEXT, pick_byte());
                            end
                        endcase
                        send_item(KIND_END, 8'($urandom));
                    end
                end
            end
            send_item(KIND_END, 8'($urandom));
            drain();
            c.weight_char     = rand_weight();
            c.weight_consec   = rand_weight();
            c.weight_start    = rand_weight();
            c.weight_boundary = rand_weight();
            c.weight_gap      = rand_weight();
            c.miss_score      = rand_fixed();
            c.exact_score     = rand_fixed();
            c.prefix_score    = rand_fixed();
            load_config(c);
        end

        repeat (16) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fss_pkg.sv
hdl/fss_pattern_mem.sv
hdl/fss_scan.sv
hdl/fuzzy_subsequence_scorer_top.sv
bench/fuzzy_subsequence_scorer_top_tb.sv
